// ----- hdl/utfs_pkg.sv -----
// utfs_pkg: types, constants and the UTF-8 encode function of the UTF-16 to
// UTF-8 stream converter. No dependencies.
package utfs_pkg;

   localparam int CpWidth = 22;

   localparam logic [15:0] SurrLo = 16'hD800;
   localparam logic [15:0] SurrHi = 16'hDFFF;
   // 0x10000 - 0xDC00: folds the pair formula into one add
   localparam logic [CpWidth-1:0] PairBias = 22'h002400;

   localparam logic [CpWidth-1:0] Lim1 = 22'h000080;
   localparam logic [CpWidth-1:0] Lim2 = 22'h000800;
   localparam logic [CpWidth-1:0] Lim3 = 22'h010000;

   localparam logic [7:0] Lead2 = 8'hC0;
   localparam logic [7:0] Lead3 = 8'hE0;
   localparam logic [7:0] Lead4 = 8'hF0;
   localparam logic [7:0] Cont  = 8'h80;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        final_unit;
   } utfs_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } utfs_rsp_type;

   // one encoded code point: byte k in seq[k], last_idx = length - 1
   typedef struct packed {
      logic [3:0][7:0] seq;
      logic [1:0]      last_idx;
   } utfs_desc_type;

   function automatic utfs_desc_type utfs_encode(input logic [CpWidth-1:0] cp);
      utfs_desc_type d;
      d = '0;
      if (cp < Lim1) begin
         d.seq[0]   = {1'b0, cp[6:0]};
         d.last_idx = 2'd0;
      end else if (cp < Lim2) begin
         d.seq[0]   = Lead2 | {3'b000, cp[10:6]};
         d.seq[1]   = Cont | {2'b00, cp[5:0]};
         d.last_idx = 2'd1;
      end else if (cp < Lim3) begin
         d.seq[0]   = Lead3 | {4'b0000, cp[15:12]};
         d.seq[1]   = Cont | {2'b00, cp[11:6]};
         d.seq[2]   = Cont | {2'b00, cp[5:0]};
         d.last_idx = 2'd2;
      end else begin
         // 4-byte form keeps the low 21 bits only
         d.seq[0]   = Lead4 | {5'b00000, cp[20:18]};
         d.seq[1]   = Cont | {2'b00, cp[17:12]};
         d.seq[2]   = Cont | {2'b00, cp[11:6]};
         d.seq[3]   = Cont | {2'b00, cp[5:0]};
         d.last_idx = 2'd3;
      end
      return d;
   endfunction

endpackage

// ----- hdl/utfs_front.sv -----
// utfs_front: accepts code units, pairs surrogates and encodes each code point
// into a byte descriptor. Depends on utfs_pkg.
module utfs_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  utfs_pkg::utfs_req_type req_word,
   output logic                   req_full,
   input  logic                   q_full,
   output logic                   q_push,
   output utfs_pkg::utfs_desc_type q_desc
);
   import utfs_pkg::*;

   logic              pending_ff, pending_in;
   logic [10:0]       hi_ff, hi_in;
   logic              accept;
   logic              is_surr;
   logic [CpWidth-1:0] cp;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign is_surr  = (req_word.code_unit >= SurrLo) && (req_word.code_unit <= SurrHi);

   always_comb begin
      if (pending_ff) begin
         cp = {1'b0, hi_ff, 10'b0} + {6'b0, req_word.code_unit} + PairBias;
      end else begin
         cp = {6'b0, req_word.code_unit};
      end
   end

   assign q_push = accept && (pending_ff || !is_surr);
   assign q_desc = utfs_encode(cp);

   always_comb begin
      pending_in = pending_ff;
      hi_in      = hi_ff;
      if (accept) begin
         if (pending_ff) begin
            pending_in = 1'b0;
            hi_in      = '0;
         end else if (is_surr && !req_word.final_unit) begin
            pending_in = 1'b1;
            hi_in      = req_word.code_unit[10:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         hi_ff      <= '0;
      end else begin
         pending_ff <= pending_in;
         hi_ff      <= hi_in;
      end
   end

   a_pair_clears: assert property (@(posedge clock) disable iff (reset)
      accept && pending_ff |=> !pending_ff)
      else $error("held surrogate not released");
   a_pair_emits: assert property (@(posedge clock) disable iff (reset)
      accept && pending_ff |-> q_push)
      else $error("pair produced no code point");

endmodule

// ----- hdl/utfs_queue.sv -----
// utfs_queue: two-entry descriptor queue between front and back.
// Depends on utfs_pkg.
module utfs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  utfs_pkg::utfs_desc_type din,
   output logic                    full,
   input  logic                    pop,
   output utfs_pkg::utfs_desc_type dout,
   output logic                    empty
);
   import utfs_pkg::*;

   utfs_desc_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count out of range");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from empty queue");

endmodule

// ----- hdl/utfs_back.sv -----
// utfs_back: walks each descriptor byte by byte into the registered result
// stage. Depends on utfs_pkg.
module utfs_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  utfs_pkg::utfs_desc_type q_desc,
   output logic                    q_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output utfs_pkg::utfs_rsp_type  rsp_word
);
   import utfs_pkg::*;

   utfs_desc_type desc_ff, desc_in;
   logic [1:0]    idx_ff, idx_in;
   logic          busy_ff, busy_in;
   utfs_rsp_type  out_ff, out_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_free, step, done;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign step      = busy_ff && out_free;
   assign done      = step && (idx_ff == desc_ff.last_idx);
   assign q_pop     = !q_empty && (!busy_ff || done);
   assign rsp_empty = !out_valid_ff;
   assign rsp_word  = out_ff;

   always_comb begin
      desc_in      = desc_ff;
      idx_in       = idx_ff;
      busy_in      = busy_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (step) begin
         out_in.out_byte = desc_ff.seq[idx_ff];
         out_in.run_last = done;
         out_valid_in    = 1'b1;
         idx_in          = idx_ff + 2'd1;
         if (done) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         desc_in = q_desc;
         idx_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      out_ff  <= out_in;
      if (reset) begin
         idx_ff       <= '0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= desc_ff.last_idx)
      else $error("byte index past descriptor length");

endmodule

// ----- hdl/utf16_to_utf8_stream.sv -----
// utf16_to_utf8_stream: top level of the UTF-16 to UTF-8 converter.
// Depends on utfs_pkg, utfs_front, utfs_queue and utfs_back.
//
// Usage:
//  - Input channel (req_): one UTF-16 code unit per word, with final_unit
//    marking the last unit of a string. A word is taken on a clock edge with
//    req_push high and req_full low.
//  - Result channel (rsp_): one UTF-8 byte per word, run_last set on the last
//    byte produced by an input word. The byte on rsp_word is valid while
//    rsp_empty is low and is taken on an edge with rsp_pop high.
//  - A leading surrogate (D800-DFFF, nothing held) is stored and yields no
//    bytes; the next unit, whatever it is, completes the pair. A surrogate
//    arriving as the final unit with nothing held is dropped.
//  - A code point passes through the queue slot, the back end's descriptor
//    register and the result register before its first byte shows.
//    Throughput: one byte per cycle at the result side while the receiver
//    pops each byte, the byte walker in the back end setting this rate.
//    Units enter back to back while the two-entry descriptor queue has room.
//  - Reset (synchronous) drops any held surrogate and all queued bytes.
//  - A stalled receiver fills the result register, then the queue, then
//    raises req_full; nothing is lost.
module utf16_to_utf8_stream (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  utfs_pkg::utfs_req_type req_word,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output utfs_pkg::utfs_rsp_type rsp_word
);
   import utfs_pkg::*;

   // front -> queue
   logic          q_push;
   logic          q_full;
   utfs_desc_type q_din;
   // queue -> back
   logic          q_pop;
   logic          q_empty;
   utfs_desc_type q_dout;

   // classify, pair surrogates, encode
   utfs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_word (req_word),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_desc   (q_din)
   );

   // decouples encode from byte output
   utfs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   // one byte per cycle into the result register while it is free
   utfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_desc    (q_dout),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule
